// ===== src/can_encoder_multiturn_tracker_defines.svh =====
// assertion macros used by the tracker top level
`ifndef CAN_ENCODER_MULTITURN_TRACKER_DEFINES_SVH
`define CAN_ENCODER_MULTITURN_TRACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CEMT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CEMT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cemt_pkg.sv =====
`default_nettype none

package cemt_pkg;

    // default channel geometry
    localparam int MOTOR_PERIOD_DEF     = 8192;
    localparam int ENCODER_PERIOD_DEF   = 32768;
    localparam int MOTOR_CHANNELS_DEF   = 4;
    localparam int ENCODER_CHANNELS_DEF = 3;

    // frame identifiers of the first channel of each kind
    localparam logic [10:0] MOTOR_BASE_ID = 11'h201;
    localparam logic [10:0] ENC_BASE_ID   = 11'h007;

    // position limit after reset
    localparam logic [30:0] LIMIT_RESET = 31'd1228800;

    // only motors below this index take part in the over-range flag
    localparam int LIMIT_MOTORS = 3;

    // turn counter bounds
    localparam logic signed [15:0] TURNS_MAX = 16'sh7FFF;
    localparam logic signed [15:0] TURNS_MIN = 16'sh8000;

    // width of the intermediate sums ahead of saturation
    localparam int SAT_W = 40;
    localparam logic signed [SAT_W-1:0] SAT_HI = 40'sh00_7FFF_FFFF;
    localparam logic signed [SAT_W-1:0] SAT_LO = 40'shFF_8000_0000;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_MOTOR   = 2'd1,
        KIND_ENCODER = 2'd2
    } t_kind;

    // per-channel update result
    typedef struct packed {
        logic signed [15:0] turns;
        logic signed [31:0] cont;
    } t_track_res;

    // clamp a wide sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/cemt_frame_decode.sv =====
`default_nettype none

module cemt_frame_decode import cemt_pkg::*; #(
    parameter int MOTOR_PERIOD     = MOTOR_PERIOD_DEF,
    parameter int MOTOR_CHANNELS   = MOTOR_CHANNELS_DEF,
    parameter int ENCODER_CHANNELS = ENCODER_CHANNELS_DEF,
    localparam int AW = $clog2(MOTOR_PERIOD)
) (
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire logic [10:0]       i_frame_id,
    input  wire logic [7:0]        i_byte0,
    input  wire logic [7:0]        i_byte1,
    input  wire logic [7:0]        i_byte2,
    input  wire logic [7:0]        i_byte3,
    input  wire logic [7:0]        i_byte4,
    input  wire logic [7:0]        i_byte5,
    input  wire logic [7:0]        i_byte6,
    output t_kind                  o_kind,
    output logic [1:0]             o_chan,
    output logic [AW-1:0]          o_angle,
    output logic signed [15:0]     o_speed,
    output logic [31:0]            o_count
);

    localparam bit POW2 = (MOTOR_PERIOD & (MOTOR_PERIOD - 1)) == 0;

    logic [10:0] r_id;
    logic [7:0]  r_b0, r_b1, r_b2, r_b3, r_b4, r_b5, r_b6;
    logic [10:0] w_moff;
    logic [10:0] w_eoff;
    logic [15:0] w_word;

    // input register for the frame identifier and payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_id <= i_frame_id;
            r_b0 <= i_byte0;
            r_b1 <= i_byte1;
            r_b2 <= i_byte2;
            r_b3 <= i_byte3;
            r_b4 <= i_byte4;
            r_b5 <= i_byte5;
            r_b6 <= i_byte6;
        end
    end

    // identifier decode
    always_comb begin
        w_moff = r_id - MOTOR_BASE_ID;
        w_eoff = r_id - ENC_BASE_ID;
        o_kind = KIND_UNKNOWN;
        o_chan = 2'd0;
        if (r_id >= MOTOR_BASE_ID && r_id < MOTOR_BASE_ID + 11'(MOTOR_CHANNELS)) begin
            o_kind = KIND_MOTOR;
            o_chan = w_moff[1:0];
        end else if (r_id >= ENC_BASE_ID && r_id < ENC_BASE_ID + 11'(ENCODER_CHANNELS)) begin
            o_kind = KIND_ENCODER;
            o_chan = w_eoff[1:0];
        end
    end

    // payload fields
    assign w_word  = {r_b0, r_b1};
    assign o_speed = $signed({r_b2, r_b3});
    assign o_count = {r_b6, r_b5, r_b4, r_b3};

    // angle reduced to one motor period
    generate
        if (POW2) begin : g_mask
            assign o_angle = w_word[AW-1:0];
        end else begin : g_recip
            localparam int RECIP = (1 << 24) / MOTOR_PERIOD;
            logic [32:0] w_prod;
            logic [8:0]  r_q;
            logic [25:0] w_qp;
            logic [16:0] w_rem;
            logic [16:0] w_red;

            // quotient estimate on the way in, exact or one low
            assign w_prod = 33'({i_byte0, i_byte1}) * 33'(RECIP);
            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_q <= w_prod[32:24];
                end
            end

            // remainder with one correction step
            assign w_qp   = 26'(r_q) * 26'(MOTOR_PERIOD);
            assign w_rem  = {1'b0, w_word} - w_qp[16:0];
            assign w_red  = (w_rem >= 17'(MOTOR_PERIOD)) ? w_rem - 17'(MOTOR_PERIOD) : w_rem;
            assign o_angle = w_red[AW-1:0];
        end
    endgenerate

endmodule

`default_nettype wire

// ===== src/cemt_motor_track.sv =====
`default_nettype none

module cemt_motor_track import cemt_pkg::*; #(
    parameter int MOTOR_PERIOD   = MOTOR_PERIOD_DEF,
    parameter int MOTOR_CHANNELS = MOTOR_CHANNELS_DEF,
    localparam int AW = $clog2(MOTOR_PERIOD)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_upd,
    input  wire logic [1:0]    i_chan,
    input  wire logic [AW-1:0] i_angle,
    input  wire logic [30:0]   i_limit,
    output t_track_res         o_res,
    output logic               o_over_range
);

    localparam int CW    = (MOTOR_CHANNELS > 1) ? $clog2(MOTOR_CHANNELS) : 1;
    localparam int BW    = 16 + AW;
    localparam int LIM_N = (MOTOR_CHANNELS < LIMIT_MOTORS) ? MOTOR_CHANNELS : LIMIT_MOTORS;
    localparam logic signed [AW+1:0] P_S = (AW + 2)'(MOTOR_PERIOD);
    localparam logic signed [BW-1:0] P_B = BW'(MOTOR_PERIOD);

    logic [AW-1:0]        r_last   [MOTOR_CHANNELS];
    logic signed [15:0]   r_turns  [MOTOR_CHANNELS];
    logic [AW-1:0]        r_offset [MOTOR_CHANNELS];
    logic signed [BW-1:0] r_base   [MOTOR_CHANNELS];
    logic signed [31:0]   r_cont   [MOTOR_CHANNELS];

    logic [CW-1:0]        w_idx;
    logic                 w_capture;
    logic signed [AW:0]   w_jump;
    logic signed [AW+1:0] w_jump2;
    logic                 w_fwd;
    logic                 w_back;
    logic signed [15:0]   n_turns;
    logic signed [BW-1:0] n_base;
    logic [AW-1:0]        n_offset;
    logic signed [SAT_W-1:0] w_sum;
    logic signed [31:0]   n_cont;

    assign w_idx = i_chan[CW-1:0];

    // offset capture, wrap test and continuous position for the addressed motor
    always_comb begin
        w_capture = (r_offset[w_idx] == '0) && (i_angle > AW'(1)) && (r_last[w_idx] == '0);
        w_jump    = $signed({1'b0, r_last[w_idx]}) - $signed({1'b0, i_angle});
        w_jump2   = {w_jump, 1'b0};
        w_fwd     = !w_capture && (w_jump2 >= P_S) && (r_turns[w_idx] != TURNS_MAX);
        w_back    = !w_capture && (w_jump2 <= -P_S) && (r_turns[w_idx] != TURNS_MIN);
        n_turns   = r_turns[w_idx];
        n_base    = r_base[w_idx];
        if (w_fwd) begin
            n_turns = r_turns[w_idx] + 16'sd1;
            n_base  = r_base[w_idx] + P_B;
        end else if (w_back) begin
            n_turns = r_turns[w_idx] - 16'sd1;
            n_base  = r_base[w_idx] - P_B;
        end
        n_offset = w_capture ? i_angle : r_offset[w_idx];
        w_sum    = SAT_W'(n_base) + $signed(SAT_W'(i_angle)) - $signed(SAT_W'(n_offset));
        n_cont   = sat32(w_sum);
    end

    assign o_res.turns = n_turns;
    assign o_res.cont  = n_cont;

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTOR_CHANNELS; i++) begin
                r_last[i]   <= '0;
                r_turns[i]  <= '0;
                r_offset[i] <= '0;
                r_base[i]   <= '0;
                r_cont[i]   <= '0;
            end
        end else if (i_upd) begin
            r_last[w_idx]   <= i_angle;
            r_turns[w_idx]  <= n_turns;
            r_offset[w_idx] <= n_offset;
            r_base[w_idx]   <= n_base;
            r_cont[w_idx]   <= n_cont;
        end
    end

    // over-range flag on the state as it stands after this transfer
    always_comb begin
        logic signed [31:0] p;
        logic signed [32:0] pe;
        logic signed [32:0] le;
        o_over_range = 1'b0;
        le = $signed({2'b00, i_limit});
        for (int i = 0; i < LIM_N; i++) begin
            p  = (i_upd && (w_idx == CW'(i))) ? n_cont : r_cont[i];
            pe = 33'(p);
            if (pe > le || pe < -le) begin
                o_over_range = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/cemt_enc_track.sv =====
`default_nettype none

module cemt_enc_track import cemt_pkg::*; #(
    parameter int ENCODER_PERIOD   = ENCODER_PERIOD_DEF,
    parameter int ENCODER_CHANNELS = ENCODER_CHANNELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_upd,
    input  wire logic [1:0]  i_chan,
    input  wire logic [31:0] i_count,
    output t_track_res       o_res,
    output logic signed [31:0] o_speed
);

    localparam int CW = (ENCODER_CHANNELS > 1) ? $clog2(ENCODER_CHANNELS) : 1;
    localparam int BW = 16 + $clog2(ENCODER_PERIOD);
    localparam logic signed [33:0]   P_S = 34'(ENCODER_PERIOD);
    localparam logic signed [BW-1:0] P_B = BW'(ENCODER_PERIOD);

    logic [31:0]          r_last  [ENCODER_CHANNELS];
    logic signed [15:0]   r_turns [ENCODER_CHANNELS];
    logic signed [BW-1:0] r_base  [ENCODER_CHANNELS];
    logic signed [31:0]   r_cont  [ENCODER_CHANNELS];
    logic signed [31:0]   r_prev  [ENCODER_CHANNELS];
    logic                 r_seen  [ENCODER_CHANNELS];

    logic [CW-1:0]        w_idx;
    logic signed [32:0]   w_jump;
    logic signed [33:0]   w_jump2;
    logic                 w_fwd;
    logic                 w_back;
    logic signed [15:0]   n_turns;
    logic signed [BW-1:0] n_base;
    logic signed [SAT_W-1:0] w_sum;
    logic signed [31:0]   n_cont;

    assign w_idx = i_chan[CW-1:0];

    // wrap test, skipped on the first reading of a channel
    always_comb begin
        w_jump  = $signed({1'b0, r_last[w_idx]}) - $signed({1'b0, i_count});
        w_jump2 = {w_jump, 1'b0};
        w_fwd   = r_seen[w_idx] && (w_jump2 >= P_S) && (r_turns[w_idx] != TURNS_MAX);
        w_back  = r_seen[w_idx] && (w_jump2 <= -P_S) && (r_turns[w_idx] != TURNS_MIN);
        n_turns = r_turns[w_idx];
        n_base  = r_base[w_idx];
        if (w_fwd) begin
            n_turns = r_turns[w_idx] + 16'sd1;
            n_base  = r_base[w_idx] + P_B;
        end else if (w_back) begin
            n_turns = r_turns[w_idx] - 16'sd1;
            n_base  = r_base[w_idx] - P_B;
        end
        w_sum  = SAT_W'(n_base) + $signed(SAT_W'(i_count));
        n_cont = sat32(w_sum);
    end

    assign o_res.turns = n_turns;
    assign o_res.cont  = n_cont;

    // speed is the delta that the previous transfer produced
    assign o_speed = sat32(SAT_W'(r_cont[w_idx]) - SAT_W'(r_prev[w_idx]));

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENCODER_CHANNELS; i++) begin
                r_last[i]  <= '0;
                r_turns[i] <= '0;
                r_base[i]  <= '0;
                r_cont[i]  <= '0;
                r_prev[i]  <= '0;
                r_seen[i]  <= 1'b0;
            end
        end else if (i_upd) begin
            r_last[w_idx]  <= i_count;
            r_turns[w_idx] <= n_turns;
            r_base[w_idx]  <= n_base;
            r_cont[w_idx]  <= n_cont;
            r_prev[w_idx]  <= r_cont[w_idx];
            r_seen[w_idx]  <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== src/can_encoder_multiturn_tracker.sv =====
`default_nettype none

// Unwraps single-turn readings carried in received CAN frames into continuous
// positions, one frame per transfer and one result per frame. Motor frames
// (ids 0x201 up) and absolute-encoder frames (ids 0x07 up) each update their
// own channel; any other id returns an all-zero result with the over-range
// flag of the current motor state. The block takes one frame every clock
// cycle while the result output is not stalled: a frame sits in the input
// register while the channel update is worked out, and its result is loaded
// into the output register when the frame advances. Frames for the same
// channel may follow each other back to back, because the channel registers
// are written on the same edge that loads the result. The position limit may
// be written only while no frame is in flight. Reset clears every channel's
// history and restores the default limit.

`include "can_encoder_multiturn_tracker_defines.svh"

module can_encoder_multiturn_tracker import cemt_pkg::*; #(
    parameter int MOTOR_PERIOD     = MOTOR_PERIOD_DEF,
    parameter int ENCODER_PERIOD   = ENCODER_PERIOD_DEF,
    parameter int MOTOR_CHANNELS   = MOTOR_CHANNELS_DEF,
    parameter int ENCODER_CHANNELS = ENCODER_CHANNELS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration
    input  wire logic         i_cfg_we,
    input  wire logic [30:0]  i_cfg_wdata,
    // frame input
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [10:0]  i_frame_id,
    input  wire logic [7:0]   i_byte0,
    input  wire logic [7:0]   i_byte1,
    input  wire logic [7:0]   i_byte2,
    input  wire logic [7:0]   i_byte3,
    input  wire logic [7:0]   i_byte4,
    input  wire logic [7:0]   i_byte5,
    input  wire logic [7:0]   i_byte6,
    // result output
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [1:0]        o_source_kind,
    output logic [1:0]        o_channel,
    output logic [31:0]       o_raw_position,
    output logic signed [31:0] o_speed,
    output logic signed [15:0] o_turns,
    output logic signed [31:0] o_continuous_position,
    output logic              o_over_range
);

    localparam int AW = $clog2(MOTOR_PERIOD);

    logic        r_limit;
    logic [30:0] r_pos_limit;
    logic        r_in_valid;
    logic        r_out_valid;
    logic        w_load;
    logic        w_adv;

    t_kind              w_kind;
    logic [1:0]         w_chan;
    logic [AW-1:0]      w_angle;
    logic signed [15:0] w_mspeed;
    logic [31:0]        w_count;
    t_track_res         w_mres;
    t_track_res         w_eres;
    logic signed [31:0] w_espeed;
    logic               w_over;

    logic [1:0]         n_kind;
    logic [1:0]         n_chan;
    logic [31:0]        n_raw;
    logic signed [31:0] n_speed;
    logic signed [15:0] n_turns;
    logic signed [31:0] n_cont;

    logic [1:0]         r_kind;
    logic [1:0]         r_chan;
    logic [31:0]        r_raw;
    logic signed [31:0] r_speed;
    logic signed [15:0] r_turns;
    logic signed [31:0] r_cont;
    logic               r_over;

    // position limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_limit <= LIMIT_RESET;
            r_limit     <= 1'b0;
        end else if (i_cfg_we) begin
            r_pos_limit <= i_cfg_wdata;
            r_limit     <= 1'b1;
        end
    end

    // pipeline handshake
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    cemt_frame_decode #(
        .MOTOR_PERIOD     (MOTOR_PERIOD),
        .MOTOR_CHANNELS   (MOTOR_CHANNELS),
        .ENCODER_CHANNELS (ENCODER_CHANNELS)
    ) u_decode (
        .i_clk      (i_clk),
        .i_load     (w_load),
        .i_frame_id (i_frame_id),
        .i_byte0    (i_byte0),
        .i_byte1    (i_byte1),
        .i_byte2    (i_byte2),
        .i_byte3    (i_byte3),
        .i_byte4    (i_byte4),
        .i_byte5    (i_byte5),
        .i_byte6    (i_byte6),
        .o_kind     (w_kind),
        .o_chan     (w_chan),
        .o_angle    (w_angle),
        .o_speed    (w_mspeed),
        .o_count    (w_count)
    );

    cemt_motor_track #(
        .MOTOR_PERIOD   (MOTOR_PERIOD),
        .MOTOR_CHANNELS (MOTOR_CHANNELS)
    ) u_motor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upd        (w_adv && (w_kind == KIND_MOTOR)),
        .i_chan       (w_chan),
        .i_angle      (w_angle),
        .i_limit      (r_pos_limit),
        .o_res        (w_mres),
        .o_over_range (w_over)
    );

    cemt_enc_track #(
        .ENCODER_PERIOD   (ENCODER_PERIOD),
        .ENCODER_CHANNELS (ENCODER_CHANNELS)
    ) u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_adv && (w_kind == KIND_ENCODER)),
        .i_chan  (w_chan),
        .i_count (w_count),
        .o_res   (w_eres),
        .o_speed (w_espeed)
    );

    // result selection by source kind
    always_comb begin
        n_kind  = KIND_UNKNOWN;
        n_chan  = 2'd0;
        n_raw   = '0;
        n_speed = '0;
        n_turns = '0;
        n_cont  = '0;
        unique case (w_kind)
            KIND_MOTOR: begin
                n_kind  = KIND_MOTOR;
                n_chan  = w_chan;
                n_raw   = 32'(w_angle);
                n_speed = 32'(w_mspeed);
                n_turns = w_mres.turns;
                n_cont  = w_mres.cont;
            end
            KIND_ENCODER: begin
                n_kind  = KIND_ENCODER;
                n_chan  = w_chan;
                n_raw   = w_count;
                n_speed = w_espeed;
                n_turns = w_eres.turns;
                n_cont  = w_eres.cont;
            end
            default: begin
                n_kind = KIND_UNKNOWN;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_kind  <= n_kind;
            r_chan  <= n_chan;
            r_raw   <= n_raw;
            r_speed <= n_speed;
            r_turns <= n_turns;
            r_cont  <= n_cont;
            r_over  <= w_over;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_source_kind         = r_kind;
    assign o_channel             = r_chan;
    assign o_raw_position        = r_raw;
    assign o_speed               = r_speed;
    assign o_turns               = r_turns;
    assign o_continuous_position = r_cont;
    assign o_over_range          = r_over;

    // checks on the pipeline and result contents
    `CEMT_ASSERT_NOW(a_no_adv_when_held, i_clk, i_rst_n, r_out_valid && i_out_stall, !w_adv, "result overwritten while stalled")
    `CEMT_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, w_adv, o_out_valid, "advanced item produced no result")
    `CEMT_ASSERT_NOW(a_unknown_zero, i_clk, i_rst_n, o_out_valid && (o_source_kind == KIND_UNKNOWN), (o_turns == 16'sd0) && (o_continuous_position == 32'sd0) && (o_raw_position == 32'd0), "unknown frame with nonzero result")
    `CEMT_ASSERT_NOW(a_motor_chan_range, i_clk, i_rst_n, o_out_valid && (o_source_kind == KIND_MOTOR), 32'(o_channel) < 32'(MOTOR_CHANNELS), "motor channel out of range")
    `CEMT_ASSERT_NEXT(a_limit_write, i_clk, i_rst_n, i_cfg_we, r_limit && (r_pos_limit == $past(i_cfg_wdata)), "limit write lost")

endmodule

`default_nettype wire
